// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the reservation ring.
// No dependencies; included by transactional_reservation_ring, which carries the assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define TRR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("ring invariant violated");

// The consequent holds in the cycle after the antecedent.
`define TRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ring sequencing violated");

`endif

// ===== hw/rtl/trr_pkg.sv =====
// Types and codes of the transactional reservation ring.
// No dependencies; imported by transactional_reservation_ring and its testbench.
package trr_pkg;

  typedef enum logic [1:0] {
    TAG_EMPTY,
    TAG_RESERVED,
    TAG_COMMITTED,
    TAG_ABORTED
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [31:0] price_bits;
    logic [63:0] volume;
  } payload_t;

  localparam logic [2:0] REQ_RESERVE = 3'd0;
  localparam logic [2:0] REQ_COMMIT  = 3'd1;
  localparam logic [2:0] REQ_ABORT   = 3'd2;
  localparam logic [2:0] REQ_GET     = 3'd3;
  localparam logic [2:0] REQ_TICK    = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SPACE  = 3'd1;
  localparam logic [2:0] ST_NO_MORE   = 3'd2;
  localparam logic [2:0] ST_NOT_READY = 3'd3;
  localparam logic [2:0] ST_STALE     = 3'd4;

  localparam logic [31:0] STALL_RESET = 32'd10000;

endpackage

// ===== hw/rtl/transactional_reservation_ring.sv =====
// Reserve/commit ring buffer: a ring of SLOTS slots kept in two synchronous memories,
// one for tag and tick stamp and one for the committed payload. Each request word yields
// exactly one result word. A request is a memory read, then an evaluate and write-back
// step, and get next adds one read-modify-write of the tag memory for each aborted or
// timed-out slot that it frees. The next request is taken while a result still waits in
// the output register. After reset a clearing pass that writes each slot in turn empties
// the tag memory before the first request is taken; writes to the stall limit register
// are taken at any time.
`include "assert_macros.svh"

module transactional_reservation_ring
  import trr_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_stall_limit,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic [31:0]        in_slot_pos,
  input  logic [31:0]        in_price_bits,
  input  logic signed [63:0] in_volume,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [31:0]        out_pos,
  output logic [31:0]        out_price_bits,
  output logic signed [63:0] out_volume
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [31:0] SLOTS32 = 32'(SLOTS);
  localparam logic [IDX_W:0] SLOTS_X = (IDX_W + 1)'(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [31:0]        tail_r, tail_nxt;
  logic [31:0]        head_r, head_nxt;
  logic [31:0]        tick_r, tick_nxt;
  logic [IDX_W-1:0]   tail_idx_r, tail_idx_nxt;
  logic [IDX_W-1:0]   head_idx_r, head_idx_nxt;
  logic [31:0]        stall_limit_r, stall_limit_nxt;
  logic [2:0]         req_r, req_nxt;
  logic [31:0]        pos_r, pos_nxt;
  payload_t           pay_r, pay_nxt;
  logic               win_r, win_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_status_r, out_status_nxt;
  logic [31:0]        out_pos_r, out_pos_nxt;
  logic [31:0]        out_price_r, out_price_nxt;
  logic [63:0]        out_volume_r, out_volume_nxt;

  entry_t             entry_mem [SLOTS];
  payload_t           pay_mem [SLOTS];
  entry_t             entry_q;
  payload_t           pay_q;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               ent_we;
  logic [IDX_W-1:0]   ent_waddr;
  entry_t             ent_wdata;
  logic               pay_we;

  logic               accept;
  logic               out_free;
  logic [31:0]        window;
  logic [31:0]        offset;
  logic               in_win;
  logic [IDX_W:0]     idx_sum;
  logic [IDX_W:0]     idx_fold;
  logic [IDX_W-1:0]   pos_idx;
  logic [31:0]        head_inc;
  logic [31:0]        tail_inc;
  logic [IDX_W-1:0]   head_idx_inc;
  logic [IDX_W-1:0]   tail_idx_inc;
  logic               stale;
  logic               timed_out;
  logic               skip;

  assign cfg_ready      = 1'b1;
  assign in_stall       = (state_r != S_IDLE);
  assign accept         = in_valid && (state_r == S_IDLE);
  assign out_free       = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_pos        = out_pos_r;
  assign out_price_bits = out_price_r;
  assign out_volume     = out_volume_r;

  // Slot index of a request position, derived from the head index so that no modulo is
  // needed. A position that wrapped past zero inside the window is below SLOTS itself.
  assign window   = tail_r - head_r;
  assign offset   = in_slot_pos - head_r;
  assign in_win   = offset < window;
  assign idx_sum  = {1'b0, head_idx_r} + {1'b0, offset[IDX_W-1:0]};
  assign idx_fold = (idx_sum >= SLOTS_X) ? idx_sum - SLOTS_X : idx_sum;
  assign pos_idx  = (in_slot_pos < head_r) ? in_slot_pos[IDX_W-1:0] : idx_fold[IDX_W-1:0];

  assign head_inc     = head_r + 32'd1;
  assign tail_inc     = tail_r + 32'd1;
  assign head_idx_inc = (head_inc == 32'd0 || head_idx_r == LAST_IDX) ? '0 :
                        head_idx_r + IDX_W'(1);
  assign tail_idx_inc = (tail_inc == 32'd0 || tail_idx_r == LAST_IDX) ? '0 :
                        tail_idx_r + IDX_W'(1);

  assign stale     = !win_r || (entry_q.tag != TAG_RESERVED);
  assign timed_out = (tick_r - entry_q.stamp) > stall_limit_r;
  assign skip      = (state_r == S_EVAL) && (req_r == REQ_GET) && (head_r != tail_r) &&
                     ((entry_q.tag == TAG_ABORTED) ||
                      ((entry_q.tag == TAG_RESERVED) && timed_out));

  always_comb begin
    state_nxt       = state_r;
    clr_idx_nxt     = clr_idx_r;
    tail_nxt        = tail_r;
    head_nxt        = head_r;
    tick_nxt        = tick_r;
    tail_idx_nxt    = tail_idx_r;
    head_idx_nxt    = head_idx_r;
    stall_limit_nxt = cfg_valid ? cfg_stall_limit : stall_limit_r;
    req_nxt         = req_r;
    pos_nxt         = pos_r;
    pay_nxt         = pay_r;
    win_nxt         = win_r;
    idx_nxt         = idx_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_pos_nxt     = out_pos_r;
    out_price_nxt   = out_price_r;
    out_volume_nxt  = out_volume_r;
    rd_en           = 1'b0;
    rd_addr         = head_idx_r;
    ent_we          = 1'b0;
    ent_waddr       = idx_r;
    ent_wdata       = entry_q;
    pay_we          = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        ent_we          = 1'b1;
        ent_waddr       = clr_idx_r;
        ent_wdata.tag   = TAG_EMPTY;
        ent_wdata.stamp = '0;
        clr_idx_nxt     = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          req_nxt        = in_req_type;
          pos_nxt        = in_slot_pos;
          pay_nxt        = {in_price_bits, in_volume};
          win_nxt        = in_win;
          rd_en          = 1'b1;
          unique case (in_req_type) inside
            REQ_RESERVE:          rd_addr = tail_idx_r;
            REQ_COMMIT, REQ_ABORT: rd_addr = pos_idx;
            default:              rd_addr = head_idx_r;
          endcase
          idx_nxt   = rd_addr;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (skip) begin
          ent_we        = 1'b1;
          ent_wdata.tag = TAG_EMPTY;
          head_nxt      = head_inc;
          head_idx_nxt  = head_idx_inc;
          rd_en         = 1'b1;
          rd_addr       = head_idx_inc;
          idx_nxt       = head_idx_inc;
        end else if (out_free) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_pos_nxt    = '0;
          out_price_nxt  = '0;
          out_volume_nxt = '0;
          unique case (req_r) inside
            REQ_RESERVE: begin
              if (window >= SLOTS32 || entry_q.tag != TAG_EMPTY) begin
                out_status_nxt = ST_NO_SPACE;
              end else begin
                ent_we          = 1'b1;
                ent_wdata.tag   = TAG_RESERVED;
                ent_wdata.stamp = tick_r;
                out_pos_nxt     = tail_r;
                tail_nxt        = tail_inc;
                tail_idx_nxt    = tail_idx_inc;
              end
            end
            REQ_COMMIT, REQ_ABORT: begin
              out_pos_nxt = pos_r;
              if (stale) begin
                out_status_nxt = ST_STALE;
              end else begin
                ent_we        = 1'b1;
                ent_wdata.tag = (req_r == REQ_COMMIT) ? TAG_COMMITTED : TAG_ABORTED;
                pay_we        = (req_r == REQ_COMMIT);
              end
            end
            REQ_GET: begin
              if (head_r == tail_r) begin
                out_status_nxt = ST_NO_MORE;
              end else if (entry_q.tag == TAG_COMMITTED) begin
                ent_we         = 1'b1;
                ent_wdata.tag  = TAG_EMPTY;
                out_pos_nxt    = head_r;
                out_price_nxt  = pay_q.price_bits;
                out_volume_nxt = pay_q.volume;
                head_nxt       = head_inc;
                head_idx_nxt   = head_idx_inc;
              end else begin
                out_status_nxt = ST_NOT_READY;
              end
            end
            REQ_TICK: begin
              tick_nxt = tick_r + 32'd1;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_idx_r     <= '0;
      tail_r        <= '0;
      head_r        <= '0;
      tick_r        <= '0;
      tail_idx_r    <= '0;
      head_idx_r    <= '0;
      stall_limit_r <= STALL_RESET;
      req_r         <= REQ_TICK;
      win_r         <= 1'b0;
      idx_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_idx_r     <= clr_idx_nxt;
      tail_r        <= tail_nxt;
      head_r        <= head_nxt;
      tick_r        <= tick_nxt;
      tail_idx_r    <= tail_idx_nxt;
      head_idx_r    <= head_idx_nxt;
      stall_limit_r <= stall_limit_nxt;
      req_r         <= req_nxt;
      win_r         <= win_nxt;
      idx_r         <= idx_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    pos_r        <= pos_nxt;
    pay_r        <= pay_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_price_r  <= out_price_nxt;
    out_volume_r <= out_volume_nxt;
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      entry_mem[ent_waddr] <= ent_wdata;
    end
    if (rd_en) begin
      entry_q <= entry_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[idx_r] <= pay_r;
    end
    if (rd_en) begin
      pay_q <= pay_mem[rd_addr];
    end
  end

  `TRR_ASSERT_ALWAYS(a_window_bound, clk, rst_n, (tail_r - head_r) <= SLOTS32)
  `TRR_ASSERT_NEXT(a_accept_evaluates, clk, rst_n, accept, state_r == S_EVAL)
  `TRR_ASSERT_NEXT(a_skip_advances_head, clk, rst_n, skip,
                   (head_r == $past(head_r) + 32'd1) && (state_r == S_EVAL))

endmodule

// ===== test/transactional_reservation_ring_test.sv =====
// Self-checking testbench for the transactional reservation ring: a directed table and random
// request streams under several stall limits, against typed results and a ring predictor.
// Depends on trr_pkg and the transactional_reservation_ring RTL only.
`timescale 1ns / 100ps

module transactional_reservation_ring_test;
  import trr_pkg::*;

  localparam int SLOTS = 1024;
  localparam logic [31:0] RING_SLOTS = SLOTS;
  localparam logic [2:0] REQ_UNKNOWN_FIRST = 3'd5;
  localparam logic [2:0] REQ_UNKNOWN_LAST = 3'd7;
  localparam int RANDOM_PHASE_WORDS = 210;
  localparam int MAX_PRINTED_MISMATCHES = 200;

  typedef struct packed {
    logic [2:0] req;
    logic [31:0] pos;
    logic [31:0] price;
    logic signed [63:0] vol;
  } request_t;

  typedef struct packed {
    logic [2:0] status;
    logic [31:0] pos;
    logic [31:0] price;
    logic signed [63:0] vol;
  } result_t;

  typedef struct packed {
    request_t rq;
    logic known;
    result_t res;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [31:0] cfg_stall_limit;
  logic in_valid;
  logic in_stall;
  logic [2:0] in_req_type;
  logic [31:0] in_slot_pos;
  logic [31:0] in_price_bits;
  logic signed [63:0] in_volume;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic [31:0] out_pos;
  logic [31:0] out_price_bits;
  logic signed [63:0] out_volume;

  tag_t ring_tag [SLOTS];
  logic [31:0] ring_stamp [SLOTS];
  logic [31:0] ring_price [SLOTS];
  logic [63:0] ring_volume [SLOTS];
  logic [31:0] tail_pos;
  logic [31:0] head_pos;
  logic [31:0] tick_now;
  logic [31:0] stall_limit;

  result_t awaited_results [$];
  directed_row_t directed_rows [$];
  int mismatches = 0;
  int results_checked = 0;
  int words_sent = 0;
  int burst_left = 0;
  int status_count [8];

  transactional_reservation_ring #(
    .SLOTS(SLOTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_stall_limit(cfg_stall_limit),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_slot_pos(in_slot_pos),
    .in_price_bits(in_price_bits),
    .in_volume(in_volume),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_pos(out_pos),
    .out_price_bits(out_price_bits),
    .out_volume(out_volume)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("transactional_reservation_ring verification failed");
    $finish;
  end

  function automatic result_t serve_request(input request_t rq);
    result_t r;
    logic [31:0] idx;
    logic [31:0] span;
    logic [31:0] offset;
    logic [31:0] age;
    r = '0;
    span = tail_pos - head_pos;
    case (rq.req)
      REQ_RESERVE: begin
        idx = tail_pos % RING_SLOTS;
        if (span >= RING_SLOTS || ring_tag[idx] != TAG_EMPTY) begin
          r.status = ST_NO_SPACE;
        end else begin
          ring_tag[idx] = TAG_RESERVED;
          ring_stamp[idx] = tick_now;
          r.pos = tail_pos;
          tail_pos = tail_pos + 32'd1;
        end
      end
      REQ_COMMIT, REQ_ABORT: begin
        idx = rq.pos % RING_SLOTS;
        offset = rq.pos - head_pos;
        r.pos = rq.pos;
        if (offset >= span || ring_tag[idx] != TAG_RESERVED) begin
          r.status = ST_STALE;
        end else if (rq.req == REQ_COMMIT) begin
          ring_price[idx] = rq.price;
          ring_volume[idx] = rq.vol;
          ring_tag[idx] = TAG_COMMITTED;
        end else begin
          ring_tag[idx] = TAG_ABORTED;
        end
      end
      REQ_GET: begin
        r.status = ST_NO_MORE;
        for (int guard = 0; guard <= SLOTS; guard++) begin
          if (head_pos == tail_pos) begin
            r.status = ST_NO_MORE;
            break;
          end
          idx = head_pos % RING_SLOTS;
          age = tick_now - ring_stamp[idx];
          if (ring_tag[idx] == TAG_COMMITTED) begin
            r.status = ST_OK;
            r.pos = head_pos;
            r.price = ring_price[idx];
            r.vol = ring_volume[idx];
            ring_tag[idx] = TAG_EMPTY;
            head_pos = head_pos + 32'd1;
            break;
          end else if (ring_tag[idx] == TAG_ABORTED ||
                       (ring_tag[idx] == TAG_RESERVED && age > stall_limit)) begin
            ring_tag[idx] = TAG_EMPTY;
            head_pos = head_pos + 32'd1;
          end else begin
            r.status = ST_NOT_READY;
            break;
          end
        end
      end
      REQ_TICK: begin
        tick_now = tick_now + 32'd1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Commits and aborts mostly aim at a live reservation, the rest at stale or random positions.
  function automatic logic [31:0] target_pos();
    logic [31:0] span;
    logic [31:0] start;
    logic [31:0] p;
    int unsigned roll;
    span = tail_pos - head_pos;
    roll = $urandom_range(0, 99);
    if (roll < 80 && span != 0) begin
      start = $urandom_range(0, span - 1);
      p = head_pos + start;
      for (int k = 0; k < SLOTS && k < span; k++) begin
        if (ring_tag[(head_pos + (start + k) % span) % RING_SLOTS] == TAG_RESERVED) begin
          p = head_pos + (start + k) % span;
          break;
        end
      end
      return p;
    end else if (roll < 90) begin
      return $urandom_range(0, 1) ? head_pos - 32'd1 : tail_pos;
    end
    return $urandom;
  endfunction

  function automatic request_t pick_request();
    request_t rq;
    int unsigned roll;
    rq.pos = $urandom;
    rq.price = $urandom;
    rq.vol = {$urandom, $urandom};
    roll = $urandom_range(0, 99);
    if (roll < 26) begin
      rq.req = REQ_RESERVE;
    end else if (roll < 50) begin
      rq.req = REQ_COMMIT;
    end else if (roll < 62) begin
      rq.req = REQ_ABORT;
    end else if (roll < 86) begin
      rq.req = REQ_GET;
    end else if (roll < 96) begin
      rq.req = REQ_TICK;
    end else begin
      rq.req = 3'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));
    end
    if (rq.req == REQ_COMMIT || rq.req == REQ_ABORT) begin
      rq.pos = target_pos();
    end
    return rq;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < MAX_PRINTED_MISMATCHES) begin
      $display("result %0d %s: got %0h, expected %0h", results_checked, field, got, want);
    end
    mismatches++;
  endtask

  task automatic add_row(input logic [2:0] req, input logic [31:0] pos,
                         input logic [31:0] price, input logic [63:0] vol,
                         input logic known, input logic [2:0] status,
                         input logic [31:0] opos, input logic [31:0] oprice,
                         input logic [63:0] ovol);
    directed_row_t row;
    row.rq = '{req, pos, price, vol};
    row.known = known;
    row.res = '{status, opos, oprice, ovol};
    directed_rows.push_back(row);
  endtask

  task automatic send_request(input request_t rq, input logic known, input result_t typed,
                              output result_t predicted);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) :
                   $urandom_range(1, 24);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req_type <= rq.req;
    in_slot_pos <= rq.pos;
    in_price_bits <= rq.price;
    in_volume <= rq.vol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = serve_request(rq);
    awaited_results.push_back(known ? typed : predicted);
    status_count[predicted.status]++;
    words_sent++;
  endtask

  task automatic write_stall_limit(input logic [31:0] value);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_stall_limit <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    stall_limit = value;
  endtask

  always @(posedge clk) begin : receiver_stall
    int unsigned mode_left;
    int unsigned stall_pct;
    if (mode_left == 0) begin
      mode_left = $urandom_range(64, 256);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 60;
        default: stall_pct = 85;
      endcase
    end
    mode_left--;
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin : check_result
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("word with nothing awaited, status", 64'(out_status), 64'd0);
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 64'(out_status), 64'(want.status));
        if (out_pos !== want.pos) report_mismatch("pos", 64'(out_pos), 64'(want.pos));
        if (out_price_bits !== want.price)
          report_mismatch("price_bits", 64'(out_price_bits), 64'(want.price));
        if (out_volume !== want.vol) report_mismatch("volume", out_volume, want.vol);
      end
      results_checked++;
    end
  end

  initial begin : stimulus
    request_t rq;
    result_t got_pred;
    logic [31:0] limits [5];
    int waited;
    for (int i = 0; i < SLOTS; i++) begin
      ring_tag[i] = TAG_EMPTY;
      ring_stamp[i] = '0;
      ring_price[i] = '0;
      ring_volume[i] = '0;
    end
    for (int i = 0; i < 8; i++) status_count[i] = 0;
    tail_pos = '0;
    head_pos = '0;
    tick_now = '0;
    stall_limit = STALL_RESET;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_stall_limit = '0;
    in_valid = 1'b0;
    in_req_type = REQ_RESERVE;
    in_slot_pos = '0;
    in_price_bits = '0;
    in_volume = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_stall_limit(32'd2);
    add_row(REQ_GET, '0, '0, '0, 1'b1, ST_NO_MORE, '0, '0, '0);
    add_row(REQ_COMMIT, '0, '0, '0, 1'b1, ST_STALE, '0, '0, '0);
    add_row(REQ_ABORT, '1, '0, '0, 1'b1, ST_STALE, '1, '0, '0);
    add_row(REQ_TICK, '0, '0, '0, 1'b1, ST_OK, '0, '0, '0);
    add_row(REQ_RESERVE, '0, '0, '0, 1'b1, ST_OK, 32'd0, '0, '0);
    add_row(REQ_RESERVE, '0, '0, '0, 1'b1, ST_OK, 32'd1, '0, '0);
    add_row(REQ_RESERVE, '0, '0, '0, 1'b1, ST_OK, 32'd2, '0, '0);
    add_row(REQ_GET, '0, '0, '0, 1'b1, ST_NOT_READY, '0, '0, '0);
    add_row(REQ_COMMIT, 32'd1, '1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0, '0, '0, '0);
    add_row(REQ_COMMIT, 32'd1, '0, '0, 1'b1, ST_STALE, 32'd1, '0, '0);
    add_row(REQ_ABORT, 32'd0, '0, '0, 1'b0, '0, '0, '0, '0);
    add_row(REQ_ABORT, 32'd0, '0, '0, 1'b1, ST_STALE, 32'd0, '0, '0);
    add_row(REQ_GET, '0, '0, '0, 1'b0, '0, '0, '0, '0);
    add_row(REQ_COMMIT, 32'd0, '0, '0, 1'b1, ST_STALE, 32'd0, '0, '0);
    add_row(REQ_RESERVE, '0, '0, '0, 1'b1, ST_OK, 32'd3, '0, '0);
    add_row(REQ_COMMIT, 32'd3, '0, 64'h8000_0000_0000_0000, 1'b0, '0, '0, '0, '0);
    add_row(REQ_TICK, '0, '0, '0, 1'b1, ST_OK, '0, '0, '0);
    add_row(REQ_TICK, '0, '0, '0, 1'b1, ST_OK, '0, '0, '0);
    add_row(REQ_TICK, '0, '0, '0, 1'b1, ST_OK, '0, '0, '0);
    add_row(REQ_GET, '0, '0, '0, 1'b0, '0, '0, '0, '0);
    add_row(REQ_GET, '0, '0, '0, 1'b1, ST_NO_MORE, '0, '0, '0);
    add_row(REQ_UNKNOWN_FIRST, '1, '1, '1, 1'b1, ST_OK, '0, '0, '0);
    add_row(REQ_UNKNOWN_LAST, '1, '1, '1, 1'b1, ST_OK, '0, '0, '0);
    add_row(REQ_ABORT, 32'd4, '0, '0, 1'b1, ST_STALE, 32'd4, '0, '0);
    add_row(REQ_RESERVE, '0, '0, '0, 1'b1, ST_OK, 32'd4, '0, '0);
    add_row(REQ_GET, '0, '0, '0, 1'b1, ST_NOT_READY, '0, '0, '0);
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].rq, directed_rows[i].known, directed_rows[i].res,
                   got_pred);
    end

    limits[0] = 32'hFFFF_FFFF;
    limits[1] = STALL_RESET;
    limits[2] = $urandom_range(1, 8);
    limits[3] = $urandom;
    limits[4] = 32'd0;
    foreach (limits[p]) begin
      write_stall_limit(limits[p]);
      repeat (RANDOM_PHASE_WORDS) begin
        rq = pick_request();
        send_request(rq, 1'b0, '0, got_pred);
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    while (awaited_results.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    if (awaited_results.size() != 0) begin
      report_mismatch("words never delivered", 64'(awaited_results.size()), 64'd0);
    end
    repeat (SLOTS + 16) @(posedge clk);

    $display("Sent %0d request words under several stall limits; %0d %s",
             words_sent, results_checked, "result words checked.");
    $display("Status mix ok/no-space/no-more/not-ready/stale: %0d/%0d/%0d/%0d/%0d",
             status_count[ST_OK], status_count[ST_NO_SPACE], status_count[ST_NO_MORE],
             status_count[ST_NOT_READY], status_count[ST_STALE]);
    if (mismatches == 0) begin
      $display("transactional_reservation_ring verification clean");
    end else begin
      $display("transactional_reservation_ring verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/trr_pkg.sv
hw/rtl/transactional_reservation_ring.sv
test/transactional_reservation_ring_test.sv
